// ----- hw/rtl/scs_pkg.sv -----
// Shared types, codes and default sizes for the segmented character stack.
// Used by scs_ctrl, scs_datapath and segmented_char_stack; depends on nothing.
package scs_pkg;

    localparam int STACK_DEPTH_DEF  = 16;
    localparam int STRING_LIMIT_DEF = 16;

    // Request codes carried in req_type.
    localparam logic [2:0] REQ_PUSH       = 3'd0;
    localparam logic [2:0] REQ_POP_NEWEST = 3'd1;
    localparam logic [2:0] REQ_POP_OLDEST = 3'd2;
    localparam logic [2:0] REQ_PEEK       = 3'd3;
    localparam logic [2:0] REQ_LENGTH     = 3'd4;

    // Result status codes.
    localparam logic [2:0] ST_CHAR    = 3'd0;
    localparam logic [2:0] ST_EMPTY   = 3'd1;
    localparam logic [2:0] ST_STORED  = 3'd2;
    localparam logic [2:0] ST_CLEARED = 3'd3;
    localparam logic [2:0] ST_DROPPED = 3'd4;

    typedef struct packed {
        logic [2:0] req_type;
        logic [7:0] char_value;
        logic [4:0] string_length;
        logic       first_char;
    } t_item;

    typedef struct packed {
        logic [7:0] out_char;
        logic [4:0] frame_length;
        logic [2:0] status;
        logic       last;
    } t_result;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic push;
        logic lookup;
        logic emit_empty;
        logic emit_len;
        logic begin_rd;
        logic emit_char;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_push;
        logic req_valid;
        logic frame_empty;
        logic start_bad;
        logic is_len;
        logic last_char;
    } t_stat;

endpackage

// ----- hw/rtl/scs_ctrl.sv -----
// Sequencing state machine of the segmented character stack.
// Depends on scs_pkg for the command and status structs.
module scs_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  scs_pkg::t_stat i_stat,
    output scs_pkg::t_cmd  o_cmd,
    output logic           busy
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_CHECK,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_busy;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_stat.is_push) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    o_cmd.lookup = 1'b1;
                    if (!i_stat.req_valid) begin
                        n_state = S_IDLE;
                    end else if (i_stat.frame_empty) begin
                        o_cmd.emit_empty = 1'b1;
                        n_state          = S_IDLE;
                    end else begin
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (i_stat.start_bad) begin
                    o_cmd.emit_empty = 1'b1;
                    n_state          = S_IDLE;
                end else if (i_stat.is_len) begin
                    o_cmd.emit_len = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    o_cmd.begin_rd = 1'b1;
                    n_state        = S_EMIT;
                end
            end
            S_EMIT: begin
                o_cmd.emit_char = 1'b1;
                if (i_stat.last_char) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
        end
    end

    assign busy = r_busy;

endmodule

// ----- hw/rtl/scs_datapath.sv -----
// Datapath of the segmented character stack: character and frame-start memories,
// counters, push bookkeeping and the result register. Depends on scs_pkg.
module scs_datapath #(
    parameter int STACK_DEPTH  = scs_pkg::STACK_DEPTH_DEF,
    parameter int STRING_LIMIT = scs_pkg::STRING_LIMIT_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_wdata,
    input  scs_pkg::t_item   i_item,
    input  scs_pkg::t_cmd    i_cmd,
    output scs_pkg::t_stat   o_stat,
    output logic             o_result_valid,
    output scs_pkg::t_result o_result
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int SW = ((CW > 8) ? CW : 8) + 1;
    localparam logic [SW-1:0] DEPTH_S = SW'(STACK_DEPTH);
    localparam logic [SW-1:0] LIMIT_S = SW'(STRING_LIMIT);

    logic [7:0]    char_mem  [STACK_DEPTH];
    logic [AW-1:0] frame_mem [STACK_DEPTH];

    logic             r_policy;
    scs_pkg::t_item   r_item;
    logic [CW-1:0]    r_used;
    logic [CW-1:0]    r_frames;
    logic [7:0]       r_pushed;
    logic             r_dropping;
    logic             r_cleared;
    logic [AW-1:0]    r_start;
    logic [CW-1:0]    r_left;
    logic [AW-1:0]    r_ptr;
    logic [7:0]       r_char_rd;
    logic             r_res_valid;
    scs_pkg::t_result r_res;

    logic [CW-1:0]    n_used;
    logic [CW-1:0]    n_frames;
    logic [7:0]       n_pushed;
    logic             n_dropping;
    logic             n_cleared;
    logic             n_res_valid;
    scs_pkg::t_result n_res;

    logic             push_res;
    logic [2:0]       push_status;
    logic             char_we;
    logic [AW-1:0]    char_waddr;
    logic             frame_we;
    logic [AW-1:0]    frame_waddr;
    logic [AW-1:0]    frame_wdata;

    logic [CW-1:0]    frame_len;
    logic             oldest_first;
    logic             last_char;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;

    // Push bookkeeping: capacity check on the first character, then the store.
    always_comb begin
        logic [SW-1:0] len_s;
        logic [SW-1:0] pos;
        logic [CW-1:0] u;
        logic [CW-1:0] f;
        logic [7:0]    p;
        logic          d;
        logic          c;
        logic          ignore;

        len_s  = SW'(r_item.string_length);
        u      = r_used;
        f      = r_frames;
        p      = r_pushed;
        d      = r_dropping;
        c      = r_cleared;
        ignore = 1'b0;

        n_used      = r_used;
        n_frames    = r_frames;
        n_pushed    = r_pushed;
        n_dropping  = r_dropping;
        n_cleared   = r_cleared;
        push_res    = 1'b0;
        push_status = scs_pkg::ST_STORED;
        char_we     = 1'b0;
        frame_we    = 1'b0;

        if (r_item.first_char) begin
            p = '0;
            d = 1'b0;
            c = 1'b0;
            if (len_s == '0 || len_s > LIMIT_S || len_s > DEPTH_S) begin
                d = 1'b1;
            end else if (SW'(u) + len_s > DEPTH_S) begin
                if (r_policy) begin
                    u = '0;
                    f = '0;
                    c = 1'b1;
                end else begin
                    d = 1'b1;
                end
            end
        end else if (p == '0 && !d) begin
            ignore = 1'b1;
        end

        pos = SW'(u) + SW'(p);
        if (!ignore) begin
            if (!d) begin
                if (SW'(p) >= LIMIT_S || pos >= DEPTH_S) begin
                    d = 1'b1;
                end else begin
                    char_we = 1'b1;
                end
            end
            if (p != 8'hFF) begin
                p = p + 8'd1;
            end
            n_used   = u;
            n_frames = f;
            if (SW'(p) < len_s) begin
                n_pushed   = p;
                n_dropping = d;
                n_cleared  = c;
            end else begin
                push_res   = 1'b1;
                n_pushed   = '0;
                n_dropping = 1'b0;
                n_cleared  = 1'b0;
                if (d) begin
                    push_status = scs_pkg::ST_DROPPED;
                end else begin
                    push_status = c ? scs_pkg::ST_CLEARED : scs_pkg::ST_STORED;
                    if (SW'(f) < DEPTH_S) begin
                        frame_we = 1'b1;
                        n_frames = f + CW'(1);
                    end
                    n_used = CW'(SW'(u) + SW'(p));
                end
            end
        end

        char_waddr  = pos[AW-1:0];
        frame_waddr = f[AW-1:0];
        frame_wdata = u[AW-1:0];
    end

    assign frame_len    = r_used - CW'(r_start);
    assign oldest_first = (r_item.req_type == scs_pkg::REQ_POP_OLDEST);
    assign last_char    = (r_left == CW'(1));

    // Read address: the frame's oldest or newest index, then one step per result.
    always_comb begin
        if (i_cmd.begin_rd) begin
            rd_addr = oldest_first ? r_start : AW'(r_used - CW'(1));
        end else begin
            rd_addr = oldest_first ? (r_ptr + AW'(1)) : (r_ptr - AW'(1));
        end
        rd_en = i_cmd.begin_rd || (i_cmd.emit_char && !last_char);
    end

    always_comb begin
        n_res       = '0;
        n_res.last  = 1'b1;
        n_res_valid = 1'b0;
        if (i_cmd.push && push_res) begin
            n_res_valid  = 1'b1;
            n_res.status = push_status;
        end else if (i_cmd.emit_empty) begin
            n_res_valid  = 1'b1;
            n_res.status = scs_pkg::ST_EMPTY;
        end else if (i_cmd.emit_len) begin
            n_res_valid        = 1'b1;
            n_res.status       = scs_pkg::ST_CHAR;
            n_res.frame_length = 5'(frame_len);
        end else if (i_cmd.emit_char) begin
            n_res_valid    = 1'b1;
            n_res.status   = scs_pkg::ST_CHAR;
            n_res.out_char = r_char_rd;
            n_res.last     = last_char;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy    <= 1'b0;
            r_used      <= '0;
            r_frames    <= '0;
            r_pushed    <= '0;
            r_dropping  <= 1'b0;
            r_cleared   <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= n_res_valid;
            if (i_cfg_we) begin
                r_policy <= i_cfg_wdata;
            end
            if (i_cmd.push) begin
                r_used     <= n_used;
                r_frames   <= n_frames;
                r_pushed   <= n_pushed;
                r_dropping <= n_dropping;
                r_cleared  <= n_cleared;
            end
            if (i_cmd.lookup) begin
                r_pushed   <= '0;
                r_dropping <= 1'b0;
                r_cleared  <= 1'b0;
            end
            if (i_cmd.emit_char && last_char && r_item.req_type != scs_pkg::REQ_PEEK) begin
                r_used   <= CW'(r_start);
                r_frames <= r_frames - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
        end
        if (i_cmd.push && char_we) begin
            char_mem[char_waddr] <= r_item.char_value;
        end
        if (i_cmd.push && frame_we) begin
            frame_mem[frame_waddr] <= frame_wdata;
        end
        if (i_cmd.lookup && r_frames != '0) begin
            r_start <= frame_mem[AW'(r_frames - CW'(1))];
        end
        if (rd_en) begin
            r_char_rd <= char_mem[rd_addr];
            r_ptr     <= rd_addr;
        end
        if (i_cmd.begin_rd) begin
            r_left <= frame_len;
        end else if (i_cmd.emit_char) begin
            r_left <= r_left - CW'(1);
        end
        r_res <= n_res;
    end

    assign o_stat.is_push     = (r_item.req_type == scs_pkg::REQ_PUSH);
    assign o_stat.req_valid   = (r_item.req_type <= scs_pkg::REQ_LENGTH);
    assign o_stat.frame_empty = (r_frames == '0);
    assign o_stat.start_bad   = (CW'(r_start) >= r_used);
    assign o_stat.is_len      = (r_item.req_type == scs_pkg::REQ_LENGTH);
    assign o_stat.last_char   = last_char;

    assign o_result_valid = r_res_valid;
    assign o_result       = r_res;

endmodule

// ----- hw/rtl/segmented_char_stack.sv -----
// Segmented character stack, top level; instantiates scs_ctrl and scs_datapath and
// uses the types and codes of scs_pkg.
// The block keeps whole strings as frames on a character stack, with a second
// stack of frame start indices. An item is taken when start is high and busy is
// low. A push carries one character with its string's length; the capacity check
// happens on the first character, and one status result follows the last one.
// Pops (newest-first or oldest-first) and peeks emit one character per result;
// a length request gives one result, and an empty stack gives one empty status.
// Results appear on o_result for exactly one cycle, flagged by o_result_valid;
// the receiver must take them, it cannot hold the block off. The final result of
// an item has last set. A push passes through the execute state, and its status
// is shown once the block is idle again, so the next item can be taken at the
// edge that ends it. An empty-stack answer takes the same path, and so does an
// undefined request or an ignored character, which give no result. A length
// request goes on through the check state, since the frame start memory has a
// registered read. A pop or peek goes on from the check state to the emit state:
// the character memory yields one registered read per cycle, so characters
// stream out back to back, one per cycle. The overflow policy is written through
// i_cfg_we and i_cfg_wdata; the user must write it only while the block is idle,
// and the block itself does not enforce this.
module segmented_char_stack #(
    parameter int STACK_DEPTH  = scs_pkg::STACK_DEPTH_DEF,
    parameter int STRING_LIMIT = scs_pkg::STRING_LIMIT_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  scs_pkg::t_item   i_item,
    input  logic             i_cfg_we,
    input  logic             i_cfg_wdata,
    output logic             o_result_valid,
    output scs_pkg::t_result o_result
);

    // Command and status bundles between the controller and the datapath.
    scs_pkg::t_cmd  cmd;
    scs_pkg::t_stat stat;

    // The controller steps through decode, frame lookup and character
    // streaming; it only sees status flags, never the data itself.
    scs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    // The datapath holds both memories, the counters and the result register.
    scs_datapath #(
        .STACK_DEPTH  (STACK_DEPTH),
        .STRING_LIMIT (STRING_LIMIT)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_item         (i_item),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

    // An item just taken cannot have produced a result yet in the next cycle.
    a_no_result_after_accept: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> !o_result_valid
    ) else $error("result appeared right after an item was taken");

    // Characters of one frame stream without gaps until the last one.
    a_stream_contiguous: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_result.last) |=> o_result_valid
    ) else $error("gap inside a character stream");

    // Once the final result of an item is out, the block is free again.
    a_idle_at_last: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.last) |-> !busy
    ) else $error("busy still set while the final result is shown");

    // Status results carry no character and no length.
    a_status_zero_payload: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.status != scs_pkg::ST_CHAR) |->
            (o_result.out_char == 8'd0 && o_result.frame_length == 5'd0)
    ) else $error("status result with nonzero payload");

endmodule

// ----- verif/tb_segmented_char_stack.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for segmented_char_stack: a scoreboard class predicts every
// result, and plain tasks drive items and the overflow policy register.
// Depends on scs_pkg for the item and result types and the request and status codes.
module tb_segmented_char_stack;
    import scs_pkg::*;

    localparam int DEPTH       = STACK_DEPTH_DEF;
    localparam int STR_LIMIT   = STRING_LIMIT_DEF;
    localparam int CLK_PERIOD  = 8;
    // Idle wait after the last result; it leaves margin for an item that produced no
    // result to finish before a register write.
    localparam int IDLE_SETTLE = 8;
    localparam int DRAIN_LIMIT = 5000;
    localparam int TIMEOUT_NS  = 2_000_000;
    localparam int PHASE_ITEMS = 80;
    localparam int MAX_LEN_CODE = 31;
    // Request codes the block does not define.
    localparam logic [2:0] REQ_UNUSED_LO = 3'd5;
    localparam logic [2:0] REQ_UNUSED_HI = 3'd7;

    // The scoreboard keeps its own copy of the stack and predicts the results of each
    // accepted item, then matches results as they come out, oldest first.
    class char_stack_scoreboard;
        logic [7:0] chars [DEPTH];
        int         frame_base [DEPTH];
        int         depth_used;
        int         frames_held;
        int         str_count;
        bit         str_dropping;
        bit         str_cleared;
        bit         policy;
        t_result    pending [$];
        int         fail_count;
        int         n_stored, n_cleared, n_dropped, n_empty, n_chars, n_lengths;

        function new();
            depth_used  = 0;
            frames_held = 0;
            policy      = 1'b0;
            fail_count  = 0;
            n_stored    = 0;
            n_cleared   = 0;
            n_dropped   = 0;
            n_empty     = 0;
            n_chars     = 0;
            n_lengths   = 0;
            drop_partial();
        endfunction

        // Forget any string in progress.
        function void drop_partial();
            str_count    = 0;
            str_dropping = 1'b0;
            str_cleared  = 1'b0;
        endfunction

        function void queue_result(logic [7:0] ch, logic [4:0] flen, logic [2:0] st,
                                   logic lst);
            t_result r;
            r.out_char     = ch;
            r.frame_length = flen;
            r.status       = st;
            r.last         = lst;
            pending.push_back(r);
        endfunction

        // True for items that give no result and leave the stored frames unchanged.
        function bit is_ignored(t_item it);
            if (it.req_type == REQ_PUSH)
                return !it.first_char && str_count == 0 && !str_dropping;
            return it.req_type > REQ_LENGTH;
        endfunction

        function void take_push(t_item it);
            int pos;
            if (it.first_char) begin
                drop_partial();
                if (it.string_length == 0 || it.string_length > STR_LIMIT ||
                    it.string_length > DEPTH) begin
                    str_dropping = 1'b1;
                end else if (depth_used + it.string_length > DEPTH) begin
                    if (policy) begin
                        depth_used  = 0;
                        frames_held = 0;
                        str_cleared = 1'b1;
                    end else begin
                        str_dropping = 1'b1;
                    end
                end
            end else if (str_count == 0 && !str_dropping) begin
                return;
            end
            if (!str_dropping) begin
                pos = depth_used + str_count;
                if (str_count >= STR_LIMIT || pos >= DEPTH)
                    str_dropping = 1'b1;
                else
                    chars[pos] = it.char_value;
            end
            if (str_count < 255)
                str_count++;
            // The length on the current item decides where the string ends.
            if (str_count < it.string_length)
                return;
            if (str_dropping) begin
                queue_result(8'd0, 5'd0, ST_DROPPED, 1'b1);
            end else begin
                if (frames_held < DEPTH) begin
                    frame_base[frames_held] = depth_used;
                    frames_held++;
                end
                depth_used += str_count;
                queue_result(8'd0, 5'd0, str_cleared ? ST_CLEARED : ST_STORED, 1'b1);
            end
            drop_partial();
        endfunction

        function void note_item(t_item it);
            int base, flen, idx, i;
            if (it.req_type == REQ_PUSH) begin
                take_push(it);
                return;
            end
            // Any other request abandons a string in progress.
            drop_partial();
            if (it.req_type > REQ_LENGTH)
                return;
            if (frames_held == 0 || frames_held > DEPTH) begin
                queue_result(8'd0, 5'd0, ST_EMPTY, 1'b1);
                return;
            end
            base = frame_base[frames_held - 1];
            if (base >= depth_used || depth_used > DEPTH) begin
                queue_result(8'd0, 5'd0, ST_EMPTY, 1'b1);
                return;
            end
            flen = depth_used - base;
            if (it.req_type == REQ_LENGTH) begin
                queue_result(8'd0, 5'(flen), ST_CHAR, 1'b1);
                return;
            end
            for (i = 0; i < flen; i++) begin
                idx = (it.req_type == REQ_POP_OLDEST) ? base + i : depth_used - 1 - i;
                queue_result(chars[idx], 5'd0, ST_CHAR, i == flen - 1);
            end
            if (it.req_type != REQ_PEEK) begin
                depth_used = base;
                frames_held--;
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (pending.size() == 0) begin
                $error("Unexpected result: out_char %0d frame_length %0d status %0d last %0d",
                       got.out_char, got.frame_length, got.status, got.last);
                fail_count++;
                return;
            end
            want = pending.pop_front();
            if (got.out_char !== want.out_char) begin
                $error("out_char: expected %0d, got %0d", want.out_char, got.out_char);
                fail_count++;
            end
            if (got.frame_length !== want.frame_length) begin
                $error("frame_length: expected %0d, got %0d",
                       want.frame_length, got.frame_length);
                fail_count++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                fail_count++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0d, got %0d", want.last, got.last);
                fail_count++;
            end
            case (want.status)
                ST_STORED:  n_stored++;
                ST_CLEARED: n_cleared++;
                ST_DROPPED: n_dropped++;
                ST_EMPTY:   n_empty++;
                default: begin
                    // A length answer is the only character-status result with a
                    // nonzero length, since a committed frame is never empty.
                    if (want.frame_length != 0)
                        n_lengths++;
                    else
                        n_chars++;
                end
            endcase
        endfunction
    endclass

    logic    i_clk       = 1'b0;
    logic    i_rst_n     = 1'b0;
    logic    start       = 1'b0;
    logic    i_cfg_we    = 1'b0;
    logic    i_cfg_wdata = 1'b0;
    t_item   i_item      = '0;
    logic    busy;
    logic    o_result_valid;
    t_result o_result;

    char_stack_scoreboard sb;
    bit burst = 1'b0;   // while set, items follow each other with no gap
    int items_done = 0;  // accepted items that the block acts on

    segmented_char_stack dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (i_item),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Results cannot be held off, so every strobe at a rising edge is a result taken.
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid)
            sb.check_result(o_result);
    end

    function automatic t_item random_item();
        t_item it;
        it.req_type      = 3'($urandom);
        it.char_value    = 8'($urandom);
        it.string_length = 5'($urandom);
        it.first_char    = 1'($urandom);
        return it;
    endfunction

    function automatic t_item push_item(bit first, int len, logic [7:0] ch);
        t_item it;
        it.req_type      = REQ_PUSH;
        it.char_value    = ch;
        it.string_length = 5'(len);
        it.first_char    = first;
        return it;
    endfunction

    // Requests other than push carry random values in the fields they do not use.
    function automatic t_item req_item(logic [2:0] code);
        t_item it;
        it = random_item();
        it.req_type = code;
        return it;
    endfunction

    // Presents one item after a random gap and waits until the block takes it. The
    // item is taken at the first rising edge that sees start high and busy low.
    // Start is left high on return: the caller either presents the next item in the
    // same time step or lowers start through settle.
    task automatic send_item(t_item it);
        int gap;
        if ($urandom_range(0, 39) == 0)
            burst = !burst;
        gap = burst ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            start  <= 1'b0;
            i_item <= random_item();
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        if (!sb.is_ignored(it))
            items_done++;
        sb.note_item(it);
    endtask

    task automatic push_string(int len);
        int k;
        for (k = 0; k < len; k++)
            send_item(push_item(k == 0, len, 8'($urandom)));
    endtask

    // Lets every expected result come out, then gives an item that produced no
    // result time to finish, so that the block is idle.
    task automatic settle();
        start <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge i_clk);
        repeat (IDLE_SETTLE) @(posedge i_clk);
    endtask

    task automatic write_policy(bit value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.policy = value;
    endtask

    task automatic run_directed();
        t_item it;
        write_policy(1'b0);
        // Every request on an empty stack answers with a single empty status.
        send_item(req_item(REQ_POP_NEWEST));
        send_item(req_item(REQ_POP_OLDEST));
        send_item(req_item(REQ_PEEK));
        send_item(req_item(REQ_LENGTH));
        // A two-character frame with the extreme byte values, then peek and length.
        send_item(push_item(1'b1, 2, 8'h00));
        send_item(push_item(1'b0, 2, 8'hFF));
        send_item(req_item(REQ_PEEK));
        send_item(req_item(REQ_LENGTH));
        // A continuation with no string open is ignored.
        send_item(push_item(1'b0, MAX_LEN_CODE, 8'h55));
        // An undefined request with every field bit set does nothing.
        it = push_item(1'b1, MAX_LEN_CODE, 8'hFF);
        it.req_type = REQ_UNUSED_HI;
        send_item(it);
        // Zero length drops at once; an oversize length drops, and the shorter length
        // on the next character ends the string early.
        send_item(push_item(1'b1, 0, 8'hAA));
        send_item(push_item(1'b1, STR_LIMIT + 4, 8'h11));
        send_item(push_item(1'b0, 2, 8'h22));
        // A new first character abandons the partial string.
        send_item(push_item(1'b1, 3, 8'h78));
        send_item(push_item(1'b1, 1, 8'h79));
        // A request abandons the partial string, which stays invisible.
        send_item(push_item(1'b1, 2, 8'h7A));
        send_item(req_item(REQ_LENGTH));
        // Overflow under the drop policy.
        send_item(push_item(1'b1, DEPTH, 8'h71));
        send_item(push_item(1'b0, 2, 8'h72));
        send_item(req_item(REQ_POP_OLDEST));
        send_item(req_item(REQ_POP_NEWEST));
        send_item(req_item(REQ_LENGTH));
        // Overflow under the clear policy.
        settle();
        write_policy(1'b1);
        push_string(2);
        send_item(push_item(1'b1, DEPTH, 8'h61));
        send_item(push_item(1'b0, 2, 8'h62));
        send_item(req_item(REQ_LENGTH));
    endtask

    // Mostly complete strings and requests, with broken sequences mixed in.
    task automatic run_traffic(int count);
        int pick, fit, k, stop_at;
        stop_at = items_done + count;
        while (items_done < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 42) begin
                // Short strings keep several frames on the stack; long ones can overflow it.
                if ($urandom_range(0, 9) == 0)
                    push_string($urandom_range(5, STR_LIMIT));
                else
                    push_string($urandom_range(1, 4));
            end else if (pick < 72) begin
                send_item(req_item(3'($urandom_range(REQ_POP_NEWEST, REQ_LENGTH))));
            end else begin
                case ($urandom_range(0, 6))
                    0: begin
                        send_item(push_item(1'b0, $urandom_range(0, MAX_LEN_CODE),
                                            8'($urandom)));
                    end
                    1: begin
                        send_item(req_item(3'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI))));
                    end
                    2: begin
                        // Bad length on the first character.
                        k = $urandom_range(0, 1) ? 0 : $urandom_range(STR_LIMIT + 1, MAX_LEN_CODE);
                        send_item(push_item(1'b1, k, 8'($urandom)));
                        if (k != 0)
                            send_item(push_item(1'b0, 2, 8'($urandom)));
                    end
                    3: begin
                        // Partial string cut off by a fresh first character.
                        fit = $urandom_range(1, 3);
                        for (k = 0; k < fit; k++)
                            send_item(push_item(k == 0, 4, 8'($urandom)));
                        push_string($urandom_range(1, 4));
                    end
                    4: begin
                        // Partial string cut off by a request.
                        fit = $urandom_range(1, 3);
                        for (k = 0; k < fit; k++)
                            send_item(push_item(k == 0, 5, 8'($urandom)));
                        send_item(req_item(3'($urandom_range(REQ_POP_NEWEST, REQ_UNUSED_HI))));
                    end
                    5: begin
                        // Length changing from character to character.
                        send_item(push_item(1'b1, $urandom_range(2, 8), 8'($urandom)));
                        fit = $urandom_range(1, 3);
                        for (k = 0; k < fit; k++)
                            send_item(push_item(1'b0, $urandom_range(1, MAX_LEN_CODE),
                                                8'($urandom)));
                    end
                    default: begin
                        // Claim exactly the free space, then send one character more
                        // than that, so the string runs past the top of the stack.
                        fit = DEPTH - sb.depth_used;
                        if (fit < 2) begin
                            push_string(2);
                        end else begin
                            send_item(push_item(1'b1, fit, 8'($urandom)));
                            for (k = 1; k < fit; k++)
                                send_item(push_item(1'b0, MAX_LEN_CODE, 8'($urandom)));
                            send_item(push_item(1'b0, fit + 1, 8'($urandom)));
                        end
                    end
                endcase
            end
        end
    endtask

    initial begin
        int phase, guard;
        sb = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        // Random phases alternate the policy; each write waits for an idle block.
        for (phase = 0; phase < 4; phase++) begin
            settle();
            write_policy(phase % 2 == 1);
            run_traffic(PHASE_ITEMS);
        end

        start <= 1'b0;
        guard = 0;
        while (sb.pending.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (IDLE_SETTLE) @(posedge i_clk);
        if (sb.pending.size() != 0) begin
            $error("%0d expected results never arrived", sb.pending.size());
            sb.fail_count++;
        end

        $display("Ran %0d items under both overflow policies: %0d strings stored, %0d after a clear, %0d dropped.",
                 items_done, sb.n_stored, sb.n_cleared, sb.n_dropped);
        $display("Checked %0d popped or peeked characters, %0d lengths and %0d empty answers.",
                 sb.n_chars, sb.n_lengths, sb.n_empty);
        if (sb.fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // The timeout lies far beyond the slowest legal run.
    initial begin
        #(TIMEOUT_NS);
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/scs_pkg.sv
hw/rtl/scs_ctrl.sv
hw/rtl/scs_datapath.sv
hw/rtl/segmented_char_stack.sv
verif/tb_segmented_char_stack.sv
